[rtl/core/sawf_pkg.sv]
// ----------------------------------------------------------------------------
// sawf_pkg: shared types and constants for the signed alu with flags
// operation codes, port widths and the low-byte parity helper
// ----------------------------------------------------------------------------
package sawf_pkg;

  // fixed width of the operand and value fields on the ports
  localparam int unsigned IO_W = 64;
  // default internal datapath width
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // operation selector
  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_INC = 3'd4,
    KIND_DEC = 3'd5,
    KIND_CMP = 3'd6
  } kind_t;

  // set when exactly four of the eight bits are ones
  function automatic logic parity4(input logic [7:0] x);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, x[i]};
    end
    return (n == 4'd4);
  endfunction

endpackage

[rtl/core/sawf_mul.sv]
// ----------------------------------------------------------------------------
// sawf_mul: three-stage magnitude multiplier with overflow check
// split into four half-width partial products, summed, then range checked
// ----------------------------------------------------------------------------
module sawf_mul #(
  parameter int unsigned DATA_WIDTH = sawf_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DATA_WIDTH-1:0] mag_a,
  input  logic [DATA_WIDTH-1:0] mag_b,
  input  logic                  neg,
  output logic [DATA_WIDTH-1:0] res,
  output logic                  ovf
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned H  = (W + 1) / 2;
  localparam int unsigned L  = W - H;
  localparam int unsigned PW = 2 * W;

  logic [2*H-1:0] pll_r;
  logic [H+L-1:0] plh_r;
  logic [H+L-1:0] phl_r;
  logic [2*L-1:0] phh_r;
  logic           neg1_r;
  logic [PW-1:0]  prod_r;
  logic [PW-1:0]  prod_nxt;
  logic           neg2_r;
  logic [W-1:0]   res_r;
  logic [W-1:0]   res_nxt;
  logic           ovf_r;
  logic           ovf_nxt;
  logic [W-1:0]   limit;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pll_r  <= mag_a[H-1:0] * mag_b[H-1:0];
      plh_r  <= mag_a[H-1:0] * mag_b[W-1:H];
      phl_r  <= mag_a[W-1:H] * mag_b[H-1:0];
      phh_r  <= mag_a[W-1:H] * mag_b[W-1:H];
      neg1_r <= neg && (|mag_a) && (|mag_b);
    end
  end

  // full magnitude product
  always_comb begin
    prod_nxt = PW'(pll_r)
             + ((PW'(plh_r) + PW'(phl_r)) << H)
             + (PW'(phh_r) << (2 * H));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      neg2_r <= neg1_r;
    end
  end

  // wrap, sign and range check
  always_comb begin
    limit   = neg2_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    ovf_nxt = (|prod_r[PW-1:W]) || (prod_r[W-1:0] > limit);
    res_nxt = neg2_r ? (W'(0) - prod_r[W-1:0]) : prod_r[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule

[rtl/core/signed_alu_with_flags_core.sv]
// ----------------------------------------------------------------------------
// signed_alu_with_flags_core: pipelined signed alu with status flags
// add, sub, mul, div, inc, dec and compare with sign/zero/parity/carry flags
// ----------------------------------------------------------------------------
//  channel | direction | tdata                               | tuser
//  in_     | slave     | operand_a, operand_b                | kind
//  out_    | master    | value, sign, zero, parity, carry,   | -
//          |           | divide_error                        |
//
//  one transaction is taken every cycle while the pipe is not halted
//  the pipe depth is set by the restoring divider, one quotient bit per stage
//  the multiplier runs alongside in three stages and joins the pipe early
//  reset clears only the valid bits; the whole pipe advances together and
//  halts while a result waits on out_tready
// ----------------------------------------------------------------------------
module signed_alu_with_flags_core #(
  parameter int unsigned DATA_WIDTH = sawf_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [2*sawf_pkg::IO_W-1:0] in_tdata,  // operand_a, operand_b
  input  logic [2:0]                  in_tuser,  // kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // value, sign_flag, zero_flag, parity_flag, carry_flag, divide_error, pad
  output logic [71:0]                 out_tdata
);

  localparam int unsigned W       = DATA_WIDTH;
  localparam int unsigned IOW     = sawf_pkg::IO_W;
  localparam int unsigned MUL_STG = 3;

  typedef struct packed {
    sawf_pkg::kind_t kind;
    logic [W-1:0]    res;
    logic            carry;
    logic            zcmp;
    logic            neg;
    logic            dz;
    logic [W-1:0]    rem;
    logic [W-1:0]    quo;
    logic [W-1:0]    dvs;
  } pipe_t;

  logic            en;
  logic            v0_r;
  sawf_pkg::kind_t kind0_r;
  logic [W-1:0]    a0_r;
  logic [W-1:0]    b0_r;
  pipe_t           s1_nxt;
  logic [W:0]      pv_r;
  pipe_t           pd_r [W+1];
  pipe_t           pd_nxt [W];
  logic [W-1:0]    mul_res;
  logic            mul_ovf;
  logic [W-1:0]    fin_value;
  logic            fin_zero;
  logic            fin_carry;
  logic            fin_err;
  logic            out_valid_r;
  logic [71:0]     out_data_r;
  logic [71:0]     out_data_nxt;

  // whole pipe moves when the output slot is free or being taken
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind0_r <= sawf_pkg::kind_t'(in_tuser);
      a0_r    <= in_tdata[W-1:0];
      b0_r    <= in_tdata[IOW+W-1:IOW];
    end
  end

  // add/sub/inc/dec/compare results and divider setup
  always_comb begin
    logic [W-1:0] sum;
    logic [W-1:0] dif;
    sum = a0_r + b0_r;
    dif = a0_r - b0_r;
    s1_nxt       = '0;
    s1_nxt.kind  = kind0_r;
    s1_nxt.neg   = a0_r[W-1] ^ b0_r[W-1];
    s1_nxt.dz    = (b0_r == '0);
    s1_nxt.quo   = a0_r[W-1] ? (W'(0) - a0_r) : a0_r;
    s1_nxt.dvs   = b0_r[W-1] ? (W'(0) - b0_r) : b0_r;
    case (kind0_r)
      sawf_pkg::KIND_ADD: begin
        s1_nxt.res   = sum;
        s1_nxt.carry = !(a0_r[W-1] ^ b0_r[W-1]) && (a0_r[W-1] ^ sum[W-1]);
      end
      sawf_pkg::KIND_SUB: begin
        s1_nxt.res   = dif;
        s1_nxt.carry = (a0_r[W-1] ^ b0_r[W-1]) && (a0_r[W-1] ^ dif[W-1]);
      end
      sawf_pkg::KIND_INC: begin
        s1_nxt.res   = a0_r + W'(1);
        s1_nxt.carry = (a0_r == {1'b0, {(W-1){1'b1}}});
      end
      sawf_pkg::KIND_DEC: begin
        s1_nxt.res   = a0_r - W'(1);
        s1_nxt.carry = (a0_r == {1'b1, {(W-1){1'b0}}});
      end
      sawf_pkg::KIND_CMP: begin
        s1_nxt.zcmp  = (a0_r == b0_r);
        s1_nxt.carry = ($signed(a0_r) < $signed(b0_r));
      end
      default: begin
        s1_nxt.res   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r[0] <= 1'b0;
    end else if (en) begin
      pv_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= s1_nxt;
    end
  end

  // multiplier runs beside the first divider stages
  sawf_mul #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mul (
    .clk   (clk),
    .en    (en),
    .mag_a (pd_r[0].quo),
    .mag_b (pd_r[0].dvs),
    .neg   (pd_r[0].neg),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < W; j++) begin : g_div
    always_comb begin
      pipe_t      cur;
      logic [W:0] trial;
      cur = pd_r[j];
      if (j == MUL_STG && cur.kind == sawf_pkg::KIND_MUL) begin
        cur.res   = mul_res;
        cur.carry = mul_ovf;
      end
      trial = {cur.rem, cur.quo[W-1]} - {1'b0, cur.dvs};
      pd_nxt[j] = cur;
      if (!trial[W]) begin
        pd_nxt[j].rem = trial[W-1:0];
      end else begin
        pd_nxt[j].rem = {cur.rem[W-2:0], cur.quo[W-1]};
      end
      pd_nxt[j].quo = {cur.quo[W-2:0], !trial[W]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[j+1] <= 1'b0;
      end else if (en) begin
        pv_r[j+1] <= pv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pd_r[j+1] <= pd_nxt[j];
      end
    end
  end

  // final value and flags
  always_comb begin
    fin_value = '0;
    fin_carry = 1'b0;
    fin_err   = 1'b0;
    fin_zero  = 1'b0;
    case (pd_r[W].kind)
      sawf_pkg::KIND_ADD, sawf_pkg::KIND_SUB, sawf_pkg::KIND_MUL,
      sawf_pkg::KIND_INC, sawf_pkg::KIND_DEC: begin
        fin_value = pd_r[W].res;
        fin_carry = pd_r[W].carry;
        fin_zero  = (pd_r[W].res == '0);
      end
      sawf_pkg::KIND_DIV: begin
        if (pd_r[W].dz) begin
          fin_err = 1'b1;
        end else begin
          fin_value = pd_r[W].neg ? (W'(0) - pd_r[W].quo) : pd_r[W].quo;
        end
        fin_zero = (fin_value == '0);
      end
      sawf_pkg::KIND_CMP: begin
        fin_zero  = pd_r[W].zcmp;
        fin_carry = pd_r[W].carry;
      end
      default: begin
        fin_value = '0;
      end
    endcase
    out_data_nxt          = '0;
    out_data_nxt[IOW-1:0] = IOW'($signed(fin_value));
    out_data_nxt[IOW]     = fin_value[W-1];
    out_data_nxt[IOW+1]   = fin_zero;
    out_data_nxt[IOW+2]   = sawf_pkg::parity4(fin_value[7:0]);
    out_data_nxt[IOW+3]   = fin_carry;
    out_data_nxt[IOW+4]   = fin_err;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pv_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // divide error always comes with a zero value and zero flag
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[IOW+4] |-> out_tdata[IOW-1:0] == '0 && out_tdata[IOW+1])
    else $error("divide error without zero result");

  // a divide error never also reports carry
  a_err_carry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[IOW+4] && out_tdata[IOW+3]))
    else $error("divide error together with carry");

  // an accepted transaction enters the pipe
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v0_r)
    else $error("accepted transaction lost at input");

  // a stall holds the last divider stage
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> pv_r[W] == $past(pv_r[W]))
    else $error("pipe moved during stall");

endmodule

[test/tb_signed_alu_with_flags_core.sv]
// ----------------------------------------------------------------------------
// tb_signed_alu_with_flags_core: self-checking bench for the signed alu
// directed table of corner operations, then random traffic with idle gaps,
// a long output hold-off and a drain pause; every result checked per field
// ----------------------------------------------------------------------------
module tb_signed_alu_with_flags_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_NONE = 3'd7;
  localparam logic [63:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam int N_RANDOM = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_LAT = 70;

  // field order matches out_tdata from the top bit down
  typedef struct packed {
    logic div_err, carry_f, parity_f, zero_f, sign_f;
    logic [63:0] value;
  } alu_res_t;

  typedef struct {
    logic [2:0] kind;
    logic [63:0] a, b;
    logic known;
    alu_res_t res;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;

  alu_res_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  signed_alu_with_flags_core uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic alu_res_t mk(logic [63:0] v, logic s, logic z, logic p, logic c,
                                  logic e);
    alu_res_t r;
    r.value = v; r.sign_f = s; r.zero_f = z; r.parity_f = p; r.carry_f = c; r.div_err = e;
    return r;
  endfunction

  // predicted alu outcome for one operation
  function automatic alu_res_t alu_predict(logic [2:0] kind, logic [63:0] a,
                                           logic [63:0] b);
    alu_res_t r;
    logic signed [63:0] sa, sb;
    logic signed [127:0] prod;
    logic [63:0] v, ma, mb, q;
    logic c;
    r = '0;
    sa = a; sb = b; c = 1'b0; v = '0;
    case (kind)
      sawf_pkg::KIND_ADD: begin
        v = a + b;
        c = (a[63] == b[63]) && (v[63] != a[63]);
      end
      sawf_pkg::KIND_SUB: begin
        v = a - b;
        c = (a[63] != b[63]) && (v[63] != a[63]);
      end
      sawf_pkg::KIND_MUL: begin
        prod = 128'(sa) * 128'(sb);
        v = prod[63:0];
        c = (prod != 128'(signed'(prod[63:0])));
      end
      sawf_pkg::KIND_DIV: begin
        if (b == 0) return mk('0, 0, 1, 0, 0, 1);
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        v = (a[63] ^ b[63]) ? -q : q;
      end
      sawf_pkg::KIND_INC: begin
        v = a + 1;
        c = (a == MAX_POS);
      end
      sawf_pkg::KIND_DEC: begin
        v = a - 1;
        c = (a == MIN_NEG);
      end
      sawf_pkg::KIND_CMP: return mk('0, 0, a == b, 0, sa < sb, 0);
      default: return '0;
    endcase
    return mk(v, v[63], v == 0, $countones(v[7:0]) == 4, c, 1'b0);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("t=%0t %s: got %h expected %h", $realtime, what, got, exp);
    errors++;
  endtask

  // send one transaction and queue its expectation; valid drops only in a gap
  task automatic send_op(logic [2:0] kind, logic [63:0] a, logic [63:0] b,
                         logic known, alu_res_t res);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, a};
    in_tuser <= kind;
    expected_q.push_back(known ? res : alu_predict(kind, a, b));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return 64'($urandom_range(0, 4)) - 2;
      3: return {{32{1'b0}}, $urandom()};
      4: return {{32{1'b1}}, $urandom()};
      5: return 64'(signed'($urandom_range(0, 200))) - 100;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // output side: random stalls plus one long hold-off
  always @(posedge clk) begin
    alu_res_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[68:0];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got.value, '0);
      end else begin
        exp = expected_q.pop_front();
        if (got.value !== exp.value) report_mismatch("value", got.value, exp.value);
        if (got.sign_f !== exp.sign_f) report_mismatch("sign", got.sign_f, exp.sign_f);
        if (got.zero_f !== exp.zero_f) report_mismatch("zero", got.zero_f, exp.zero_f);
        if (got.parity_f !== exp.parity_f)
          report_mismatch("parity", got.parity_f, exp.parity_f);
        if (got.carry_f !== exp.carry_f) report_mismatch("carry", got.carry_f, exp.carry_f);
        if (got.div_err !== exp.div_err) report_mismatch("div_err", got.div_err, exp.div_err);
      end
    end
    if (hold_off || !rst_n) out_tready <= 1'b0;
    else if (cycles < 3000 || cycles > 9000) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
  end

  // long receiver hold-off, counted in cycles
  initial begin
    wait (cycles == 1000);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    vec_t dir[$];
    logic [2:0] k;
    // directed table: kind, a, b, typed-in result where obvious
    dir.push_back('{sawf_pkg::KIND_DIV, 64'd5, 64'd0, 1, mk('0, 0, 1, 0, 0, 1)});
    dir.push_back('{sawf_pkg::KIND_DIV, MIN_NEG, 64'd0, 1, mk('0, 0, 1, 0, 0, 1)});
    dir.push_back('{sawf_pkg::KIND_DIV, MIN_NEG, ALL_ONES, 1, mk(MIN_NEG, 1, 0, 0, 0, 0)});
    dir.push_back('{KIND_NONE, ALL_ONES, ALL_ONES, 1, mk('0, 0, 0, 0, 0, 0)});
    dir.push_back('{sawf_pkg::KIND_CMP, 64'd3, 64'd3, 1, mk('0, 0, 1, 0, 0, 0)});
    dir.push_back('{sawf_pkg::KIND_CMP, MIN_NEG, MAX_POS, 1, mk('0, 0, 0, 0, 1, 0)});
    dir.push_back('{sawf_pkg::KIND_CMP, MAX_POS, MIN_NEG, 1, mk('0, 0, 0, 0, 0, 0)});
    dir.push_back('{sawf_pkg::KIND_INC, MAX_POS, 64'd0, 1, mk(MIN_NEG, 1, 0, 0, 1, 0)});
    dir.push_back('{sawf_pkg::KIND_DEC, MIN_NEG, 64'd0, 1, mk(MAX_POS, 0, 0, 0, 1, 0)});
    dir.push_back('{sawf_pkg::KIND_ADD, MAX_POS, 64'd1, 1, mk(MIN_NEG, 1, 0, 0, 1, 0)});
    dir.push_back('{sawf_pkg::KIND_ADD, MIN_NEG, MIN_NEG, 1, mk('0, 0, 1, 0, 1, 0)});
    dir.push_back('{sawf_pkg::KIND_SUB, MIN_NEG, 64'd1, 1, mk(MAX_POS, 0, 0, 0, 1, 0)});
    dir.push_back('{sawf_pkg::KIND_SUB, 64'd0, MIN_NEG, 0, '0});
    dir.push_back('{sawf_pkg::KIND_MUL, MIN_NEG, ALL_ONES, 0, '0});
    dir.push_back('{sawf_pkg::KIND_MUL, MAX_POS, MAX_POS, 0, '0});
    dir.push_back('{sawf_pkg::KIND_MUL, 64'h1_0000_0000, 64'h8000_0000, 0, '0});
    dir.push_back('{sawf_pkg::KIND_MUL, 64'hffff_ffff_0000_0000, 64'h8000_0000, 0, '0});
    dir.push_back('{sawf_pkg::KIND_MUL, 64'd15, 64'd1, 0, '0});
    dir.push_back('{sawf_pkg::KIND_DIV, 64'hffff_ffff_ffff_fff9, 64'd2, 0, '0});
    dir.push_back('{sawf_pkg::KIND_DIV, MAX_POS, MIN_NEG, 0, '0});
    dir.push_back('{sawf_pkg::KIND_INC, ALL_ONES, ALL_ONES, 0, '0});
    dir.push_back('{sawf_pkg::KIND_DEC, 64'd0, MAX_POS, 0, '0});
    dir.push_back('{sawf_pkg::KIND_ADD, 64'd0, 64'd0, 0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) send_op(dir[i].kind, dir[i].a, dir[i].b, dir[i].known, dir[i].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      // drain pause once midway
      if (n == N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
      end
      k = ($urandom_range(0, 30) == 0) ? KIND_NONE : 3'($urandom_range(0, 6));
      send_op(k, rand_operand(), rand_operand(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
